/* src/bounded_stack_search_remove_defines.svh */
// Assertion macros used by the back-end stack module.
`ifndef BOUNDED_STACK_SEARCH_REMOVE_DEFINES_SVH
`define BOUNDED_STACK_SEARCH_REMOVE_DEFINES_SVH

`ifndef SYNTH
`define BSSR_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("bssr assertion failed");
`define BSSR_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("bssr assertion failed");
`else
`define BSSR_ASSERT(lbl, clk, rst_n, prop)
`define BSSR_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

/* src/bssr_pkg.sv */
package bssr_pkg;

    localparam int DEPTH       = 8;
    localparam int KEY_BITS    = 64;
    localparam int KEY_W       = 64;
    localparam int COUNT_W     = 4;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_SEARCH = 2'd2,
        OP_REMOVE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]       operation;
        logic [KEY_W-1:0] key;
    } t_req;

    typedef struct packed {
        t_status            status;
        logic               found;
        logic [KEY_W-1:0]   popped_key;
        logic [COUNT_W-1:0] count;
    } t_resp;

    typedef struct packed {
        t_op                 op;
        logic [KEY_BITS-1:0] key;
    } t_cmd;

    function automatic logic [COUNT_W-1:0] count_field(input logic [CNT_W-1:0] c);
        logic [CNT_W+COUNT_W-1:0] wide;
        wide = {{COUNT_W{1'b0}}, c};
        return wide[COUNT_W-1:0];
    endfunction

    function automatic logic [KEY_W-1:0] key_field(input logic [KEY_BITS-1:0] k);
        logic [KEY_W+KEY_BITS-1:0] wide;
        wide = {{KEY_W{1'b0}}, k};
        return wide[KEY_W-1:0];
    endfunction

endpackage

/* src/bssr_ram.sv */
module bssr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/bssr_front.sv */
module bssr_front import bssr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_req i_req,
    output logic o_cmd_valid,
    output t_cmd o_cmd,
    input  logic i_cmd_take
);

    t_cmd               r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QFILL_W-1:0] r_fill;
    logic               push;
    logic               pop;
    t_cmd               cmd_in;

    assign o_stall     = (r_fill == QFILL_W'(QUEUE_DEPTH));
    assign o_cmd_valid = (r_fill != '0);
    assign o_cmd       = r_q[r_rd_ptr];
    assign push        = i_valid && !o_stall;
    assign pop         = o_cmd_valid && i_cmd_take;

    // classify: decode the operation, keep only the stored key bits
    always_comb begin
        cmd_in.op  = t_op'(i_req.operation);
        cmd_in.key = i_req.key[KEY_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cmd_in;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (pop && !push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

endmodule

/* src/bssr_back.sv */
`include "bounded_stack_search_remove_defines.svh"

module bssr_back import bssr_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_cmd_valid,
    input  t_cmd  i_cmd,
    output logic  o_cmd_take,
    output logic  o_valid,
    input  logic  i_stall,
    output t_resp o_resp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP_WAIT,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR
    } t_state;

    t_state              r_state;
    logic [CNT_W-1:0]    r_count;
    logic [IDX_W-1:0]    r_idx;
    logic [KEY_BITS-1:0] r_key;
    t_op                 r_op;
    logic                r_out_valid;
    t_resp               r_out;

    logic                take;
    logic                we;
    logic [IDX_W-1:0]    waddr;
    logic [KEY_BITS-1:0] wdata;
    logic                re;
    logic [IDX_W-1:0]    raddr;
    logic [KEY_BITS-1:0] rdata;
    logic                is_full;
    logic                is_empty;
    logic [CNT_W-1:0]    count_dec;
    logic                shift_first;
    logic                shift_more;

    assign take        = (r_state == S_IDLE) && i_cmd_valid && (!r_out_valid || !i_stall);
    assign o_cmd_take  = take;
    assign o_valid     = r_out_valid;
    assign o_resp      = r_out;
    assign is_full     = (r_count == CNT_W'(DEPTH));
    assign is_empty    = (r_count == '0);
    assign count_dec   = r_count - 1'b1;
    assign shift_first = ((CNT_W + 1)'(r_idx) + (CNT_W + 1)'(1)) < (CNT_W + 1)'(r_count);
    assign shift_more  = ((CNT_W + 1)'(r_idx) + (CNT_W + 1)'(2)) < (CNT_W + 1)'(r_count);

    always_comb begin
        we    = 1'b0;
        waddr = r_idx;
        wdata = rdata;
        re    = 1'b0;
        raddr = r_idx;
        case (r_state)
            S_IDLE: begin
                if (take && i_cmd.op == OP_PUSH && !is_full) begin
                    we    = 1'b1;
                    waddr = IDX_W'(r_count);
                    wdata = i_cmd.key;
                end else if (take && i_cmd.op == OP_POP && !is_empty) begin
                    re    = 1'b1;
                    raddr = IDX_W'(count_dec);
                end
            end
            S_SCAN_RD: begin
                re = 1'b1;
            end
            S_SHIFT_RD: begin
                re    = 1'b1;
                raddr = r_idx + 1'b1;
            end
            S_SHIFT_WR: begin
                we = 1'b1;
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    bssr_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (take) begin
                        r_key            <= i_cmd.key;
                        r_op             <= i_cmd.op;
                        r_idx            <= IDX_W'(count_dec);
                        r_out.found      <= 1'b0;
                        r_out.popped_key <= '0;
                        r_out.count      <= count_field(r_count);
                        case (i_cmd.op)
                            OP_PUSH: begin
                                r_out_valid <= 1'b1;
                                if (is_full) begin
                                    r_out.status <= ST_FULL;
                                end else begin
                                    r_out.status <= ST_OK;
                                    r_out.count  <= count_field(r_count + 1'b1);
                                    r_count      <= r_count + 1'b1;
                                end
                            end
                            OP_POP: begin
                                if (is_empty) begin
                                    r_out_valid  <= 1'b1;
                                    r_out.status <= ST_EMPTY;
                                end else begin
                                    r_state <= S_POP_WAIT;
                                end
                            end
                            OP_SEARCH: begin
                                if (is_empty) begin
                                    r_out_valid  <= 1'b1;
                                    r_out.status <= ST_NOT_FOUND;
                                end else begin
                                    r_state <= S_SCAN_RD;
                                end
                            end
                            default: begin
                                if (is_empty) begin
                                    r_out_valid  <= 1'b1;
                                    r_out.status <= ST_EMPTY;
                                end else begin
                                    r_state <= S_SCAN_RD;
                                end
                            end
                        endcase
                    end
                end
                S_POP_WAIT: begin
                    r_out_valid      <= 1'b1;
                    r_out.status     <= ST_OK;
                    r_out.popped_key <= key_field(rdata);
                    r_out.count      <= count_field(count_dec);
                    r_count          <= count_dec;
                    r_state          <= S_IDLE;
                end
                S_SCAN_RD: begin
                    r_state <= S_SCAN_CMP;
                end
                S_SCAN_CMP: begin
                    if (rdata == r_key) begin
                        if (r_op == OP_SEARCH) begin
                            r_out_valid  <= 1'b1;
                            r_out.status <= ST_OK;
                            r_out.found  <= 1'b1;
                            r_state      <= S_IDLE;
                        end else if (shift_first) begin
                            r_state <= S_SHIFT_RD;
                        end else begin
                            r_out_valid  <= 1'b1;
                            r_out.status <= ST_OK;
                            r_out.found  <= 1'b1;
                            r_out.count  <= count_field(count_dec);
                            r_count      <= count_dec;
                            r_state      <= S_IDLE;
                        end
                    end else if (r_idx == '0) begin
                        r_out_valid  <= 1'b1;
                        r_out.status <= ST_NOT_FOUND;
                        r_state      <= S_IDLE;
                    end else begin
                        r_idx   <= r_idx - 1'b1;
                        r_state <= S_SCAN_RD;
                    end
                end
                S_SHIFT_RD: begin
                    r_state <= S_SHIFT_WR;
                end
                S_SHIFT_WR: begin
                    if (shift_more) begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_SHIFT_RD;
                    end else begin
                        r_out_valid  <= 1'b1;
                        r_out.status <= ST_OK;
                        r_out.found  <= 1'b1;
                        r_out.count  <= count_field(count_dec);
                        r_count      <= count_dec;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `BSSR_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(DEPTH))
    `BSSR_ASSERT(a_busy_out_empty, i_clk, i_rst_n, (r_state != S_IDLE) |-> !r_out_valid)
    `BSSR_ASSERT(a_found_ok, i_clk, i_rst_n, r_out_valid |-> (!r_out.found || r_out.status == ST_OK))
    `BSSR_ASSERT(a_push_grows, i_clk, i_rst_n, (take && i_cmd.op == OP_PUSH && !is_full) |=> (r_count == $past(r_count) + 1'b1))

endmodule

/* src/bounded_stack_search_remove.sv */
// Bounded stack of keys with push, pop, search and remove by key.
// Request channel: i_valid / o_stall with payload i_req (operation, key);
// a request is taken at a rising edge with i_valid high and o_stall low.
// Response channel: o_valid / i_stall with payload o_resp (status, found,
// popped_key, count); exactly one response per request, in request order.
// A two-entry queue sits between the request side and the execution unit,
// so requests are taken while a response waits on a stalled receiver.
// Push writes the key in the idle state; pop reads the top entry through
// a wait state. Search compares entries from the top, each in a read and a
// compare state; remove scans the same way, then moves each entry above the
// match down one place in a read and a write state, paced by the single read
// port of the key memory. A new request starts execution only in idle.
// Reset (synchronous, active low) empties the stack and the queue and
// drops any response not yet taken. While i_stall is high a waiting response
// holds and no further request starts execution.
module bounded_stack_search_remove import bssr_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    input  t_req  i_req,
    output logic  o_valid,
    input  logic  i_stall,
    output t_resp o_resp
);

    logic cmd_valid;
    t_cmd cmd;
    logic cmd_take;

    bssr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_req       (i_req),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_take  (cmd_take)
    );

    bssr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_take  (cmd_take),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_resp      (o_resp)
    );

endmodule

/* test/bssr_checker.sv */
`timescale 1ns / 100ps

module bssr_checker import bssr_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    input  logic                i_req_stall,
    input  t_req                i_req,
    input  logic                i_resp_valid,
    input  logic                i_resp_stall,
    input  t_resp               i_resp,
    output int                  o_fails,
    output int                  o_pending,
    output int                  o_checked,
    output logic [3:0][31:0]    o_status_hits
);

    logic [KEY_BITS-1:0] stack_mem [DEPTH];
    int                  level = 0;
    int                  fail_cnt = 0;
    int                  checked_cnt = 0;
    logic [3:0][31:0]    status_hits = '0;
    t_resp               expected_q [$];

    function automatic int topmost_match(input logic [KEY_BITS-1:0] k);
        int idx;
        idx = -1;
        for (int i = level - 1; i >= 0; i--) begin
            if (stack_mem[i] == k) begin
                idx = i;
                break;
            end
        end
        return idx;
    endfunction

    // Apply one request to the shadow stack and return the response it must give.
    function automatic t_resp stack_step(input t_req rq);
        t_resp               r;
        logic [KEY_BITS-1:0] k;
        int                  pos;
        r        = '0;
        r.status = ST_OK;
        k        = rq.key[KEY_BITS-1:0];
        case (t_op'(rq.operation))
            OP_PUSH: begin
                if (level >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    stack_mem[level] = k;
                    level++;
                end
            end
            OP_POP: begin
                if (level == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    level--;
                    r.popped_key = KEY_W'(stack_mem[level]);
                end
            end
            OP_SEARCH: begin
                if (topmost_match(k) >= 0) begin
                    r.found = 1'b1;
                end else begin
                    r.status = ST_NOT_FOUND;
                end
            end
            default: begin
                if (level == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    pos = topmost_match(k);
                    if (pos < 0) begin
                        r.status = ST_NOT_FOUND;
                    end else begin
                        r.found = 1'b1;
                        for (int j = pos; j + 1 < level; j++) begin
                            stack_mem[j] = stack_mem[j + 1];
                        end
                        level--;
                    end
                end
            end
        endcase
        r.count = COUNT_W'(level);
        return r;
    endfunction

    task automatic report_field(input string field, input logic [KEY_W-1:0] exp_val,
                                input logic [KEY_W-1:0] act_val);
        if (exp_val !== act_val) begin
            fail_cnt++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field,
                     exp_val, act_val);
        end
    endtask

    always @(posedge i_clk) begin
        t_resp exp_resp;
        if (!i_rst_n) begin
            level = 0;
            expected_q.delete();
        end else begin
            if (i_resp_valid && !i_resp_stall) begin
                if (expected_q.size() == 0) begin
                    fail_cnt++;
                    $display("%0t: response with none expected, actual %0h", $time, i_resp);
                end else begin
                    exp_resp = expected_q.pop_front();
                    report_field("status", KEY_W'(exp_resp.status), KEY_W'(i_resp.status));
                    report_field("found", KEY_W'(exp_resp.found), KEY_W'(i_resp.found));
                    report_field("popped_key", exp_resp.popped_key, i_resp.popped_key);
                    report_field("count", KEY_W'(exp_resp.count), KEY_W'(i_resp.count));
                    checked_cnt++;
                    status_hits[exp_resp.status] = status_hits[exp_resp.status] + 1;
                end
            end
            if (i_req_valid && !i_req_stall) begin
                expected_q.push_back(stack_step(i_req));
            end
        end
        o_fails       <= fail_cnt;
        o_pending     <= expected_q.size();
        o_checked     <= checked_cnt;
        o_status_hits <= status_hits;
    end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
    import bssr_pkg::*;

    localparam int RANDOM_ITEMS = 1725;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 64;

    logic  i_clk = 1'b0;
    logic  i_rst_n;
    logic  i_valid;
    logic  o_stall;
    t_req  i_req;
    logic  o_valid;
    logic  i_stall;
    t_resp o_resp;

    int               fails;
    int               pending;
    int               checked;
    logic [3:0][31:0] status_hits;
    int               sent = 0;
    int               cycle_cnt = 0;
    bit               long_hold_done = 1'b0;
    logic [KEY_W-1:0] key_pool [6];

    bounded_stack_search_remove dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_resp  (o_resp)
    );

    bssr_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_valid),
        .i_req_stall   (o_stall),
        .i_req         (i_req),
        .i_resp_valid  (o_valid),
        .i_resp_stall  (i_stall),
        .i_resp        (o_resp),
        .o_fails       (fails),
        .o_pending     (pending),
        .o_checked     (checked),
        .o_status_hits (status_hits)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("bounded_stack_search_remove verification failed");
            $finish;
        end
    end

    function automatic logic [KEY_W-1:0] fresh_key();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 99) < 80) begin
            return key_pool[$urandom_range(0, 5)];
        end
        return fresh_key();
    endfunction

    // Hold the request until it is taken.
    task automatic send_req(input t_op op, input logic [KEY_W-1:0] key);
        t_req rq;
        rq.operation = op;
        rq.key       = key;
        i_valid <= 1'b1;
        i_req   <= rq;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sent++;
    endtask

    initial begin : resp_stall
        int seg;
        int pct;
        int style;
        i_stall <= 1'b0;
        forever begin
            if (!long_hold_done && sent >= 300) begin
                i_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                long_hold_done = 1'b1;
            end
            seg   = $urandom_range(5, 60);
            style = $urandom_range(0, 4);
            case (style)
                0: pct = 0;
                1: pct = 25;
                2: pct = 60;
                default: pct = 90;
            endcase
            for (int c = 0; c < seg; c++) begin
                if (style == 4) begin
                    i_stall <= c[0];
                end else begin
                    i_stall <= ($urandom_range(0, 99) < pct);
                end
                @(posedge i_clk);
            end
        end
    end

    initial begin : stimulus
        int           burst;
        int           gap;
        int           bias;
        int           r;
        int           push_pct;
        int           pop_pct;
        int           rand_sent;
        t_op          op;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_req   <= '0;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < 6; i++) key_pool[i] = fresh_key();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_req(OP_POP, fresh_key());
        send_req(OP_REMOVE, '0);
        send_req(OP_SEARCH, '1);
        send_req(OP_PUSH, '0);
        send_req(OP_PUSH, '1);
        send_req(OP_PUSH, 64'hA5A5_A5A5_A5A5_A5A5);
        send_req(OP_PUSH, 64'h5A5A_5A5A_5A5A_5A5A);
        send_req(OP_PUSH, '1);
        send_req(OP_SEARCH, '1);
        send_req(OP_SEARCH, 64'h1234);
        send_req(OP_REMOVE, 64'h1234);
        send_req(OP_REMOVE, '1);
        send_req(OP_PUSH, 64'h1);
        send_req(OP_PUSH, 64'h8000_0000_0000_0000);
        send_req(OP_PUSH, 64'h7FFF_FFFF_FFFF_FFFF);
        send_req(OP_PUSH, 64'h0000_0001_0000_0000);
        send_req(OP_PUSH, 64'd42);
        send_req(OP_SEARCH, '0);
        send_req(OP_REMOVE, '0);
        send_req(OP_REMOVE, 64'h0000_0001_0000_0000);
        send_req(OP_POP, '1);
        send_req(OP_REMOVE, '1);
        repeat (5) send_req(OP_POP, fresh_key());

        rand_sent = 0;
        bias      = 0;
        while (rand_sent < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 24);
            if ($urandom_range(0, 3) == 0) bias = $urandom_range(0, 2);
            case (bias)
                0: begin push_pct = 60; pop_pct = 15; end
                1: begin push_pct = 30; pop_pct = 25; end
                default: begin push_pct = 15; pop_pct = 35; end
            endcase
            for (int b = 0; b < burst && rand_sent < RANDOM_ITEMS; b++) begin
                r = $urandom_range(0, 99);
                if (r < push_pct) begin
                    op = OP_PUSH;
                end else if (r < push_pct + pop_pct) begin
                    op = OP_POP;
                end else begin
                    op = $urandom_range(0, 1) ? OP_SEARCH : OP_REMOVE;
                end
                send_req(op, pick_key());
                rand_sent++;
                if (rand_sent % 200 == 0) key_pool[$urandom_range(2, 5)] = fresh_key();
                if (rand_sent == 900) begin
                    i_valid <= 1'b0;
                    @(posedge i_clk);
                    while (pending != 0) @(posedge i_clk);
                    @(posedge i_clk);
                end
            end
            if ($urandom_range(0, 9) >= 3) begin
                gap = $urandom_range(1, 12);
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d requests, checked %0d responses", sent, checked);
        $display("status mix: ok %0d, full %0d, empty %0d, not found %0d",
                 status_hits[ST_OK], status_hits[ST_FULL], status_hits[ST_EMPTY],
                 status_hits[ST_NOT_FOUND]);
        if (pending != 0) $display("%0d responses never arrived", pending);
        if (fails == 0 && pending == 0) begin
            $display("bounded_stack_search_remove verification clean");
        end else begin
            $display("bounded_stack_search_remove verification failed");
        end
        $finish;
    end

endmodule
